/* src/stpq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted task priority queue package
// Item types, operation and status codes, and cell control shared by the
// queue cells and the top level.
// ----------------------------------------------------------------------------
package stpq_pkg;

    localparam int DEPTH_DEF     = 32;
    localparam int TIME_BITS_DEF = 16;
    localparam int FIELD_W       = 16;
    localparam int COUNT_W       = 6;

    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_POP  = 2'd1;
    localparam logic [1:0] FUNC_PEEK = 2'd2;
    localparam logic [1:0] FUNC_RSVD = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    localparam logic MODE_RELEASE  = 1'b0;
    localparam logic MODE_DELIVERY = 1'b1;

    typedef struct packed {
        logic [1:0]         func;
        logic [FIELD_W-1:0] release_in;
        logic [FIELD_W-1:0] process_in;
        logic [FIELD_W-1:0] delivery_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] release_out;
        logic [FIELD_W-1:0] process_out;
        logic [FIELD_W-1:0] delivery_out;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
    } t_out_item;

    typedef struct packed {
        logic push;
        logic pop;
        logic mode;
    } t_cell_ctl;

endpackage

/* src/stpq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted task priority queue cell
// Holds one task and its valid bit. On a push it either keeps its task, takes
// the new task, or takes the task of its left neighbor; on a pop it takes the
// task of its right neighbor.
// ----------------------------------------------------------------------------
module stpq_cell #(
    parameter int TIME_BITS = stpq_pkg::TIME_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  stpq_pkg::t_cell_ctl      i_ctl,
    input  logic [3*TIME_BITS-1:0]   i_new_data,
    input  logic [3*TIME_BITS-1:0]   i_left_data,
    input  logic                     i_left_valid,
    input  logic [3*TIME_BITS-1:0]   i_right_data,
    input  logic                     i_right_valid,
    input  logic                     i_found,
    output logic                     o_found,
    output logic [3*TIME_BITS-1:0]   o_data,
    output logic                     o_valid
);
    import stpq_pkg::*;

    logic [3*TIME_BITS-1:0] r_data, n_data;
    logic                   r_valid, n_valid;
    logic [TIME_BITS-1:0]   w_rel_own, w_del_own, w_rel_new, w_del_new;
    logic                   w_behind, w_stop;

    assign w_rel_own = r_data[3*TIME_BITS-1:2*TIME_BITS];
    assign w_del_own = r_data[TIME_BITS-1:0];
    assign w_rel_new = i_new_data[3*TIME_BITS-1:2*TIME_BITS];
    assign w_del_new = i_new_data[TIME_BITS-1:0];

    assign w_behind = (i_ctl.mode == MODE_RELEASE) ? (w_rel_own > w_rel_new)
                                                   : (w_del_own < w_del_new);
    assign w_stop   = !r_valid || w_behind;
    assign o_found  = i_found || w_stop;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctl.push) begin
            if (i_found) begin
                n_data  = i_left_data;
                n_valid = i_left_valid;
            end else if (w_stop) begin
                n_data  = i_new_data;
                n_valid = 1'b1;
            end
        end else if (i_ctl.pop) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

/* src/sorted_task_priority_queue.sv */
// ----------------------------------------------------------------------------
// Sorted task priority queue
// A row of cells keeps the tasks in priority order with the head in cell 0.
// Every cell compares itself against a pushed task in the same cycle.
//
//   Channel  Direction  Handshake             Payload
//   in       input      i_in_valid/o_in_stall  i_in_item (t_in_item)
//   out      output     o_out_valid/i_out_stall o_out_item (t_out_item)
//   cfg      input      i_cfg_we               i_cfg_data (order mode)
//
// Each item produces its result in the output register in the cycle after
// acceptance, so one item is taken per cycle unless the input is stalled. The
// rate is set by the compare and shift across the cell row. Input stalls
// only while the output register holds a result that is itself stalled.
// Synchronous reset empties the queue and selects release-time order.
// ----------------------------------------------------------------------------
module sorted_task_priority_queue #(
    parameter int DEPTH     = stpq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = stpq_pkg::TIME_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  stpq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output stpq_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data
);
    import stpq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENT_W = 3 * TIME_BITS;

    logic [ENT_W-1:0] w_data [DEPTH];
    logic             w_valid [DEPTH];
    logic             w_found [DEPTH+1];

    logic             r_mode;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid;
    t_out_item        r_out_item, n_out_item;

    logic             w_accept, w_full, w_empty, w_is_push, w_is_pop, w_is_peek;
    t_cell_ctl        w_ctl;
    logic [ENT_W-1:0] w_new_data;
    logic [TIME_BITS-1:0] w_head_rel, w_head_proc, w_head_del;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_empty    = !w_valid[0];
    assign w_full     = w_valid[DEPTH-1];
    assign w_is_push  = i_in_item.func == FUNC_PUSH;
    assign w_is_pop   = i_in_item.func == FUNC_POP;
    assign w_is_peek  = i_in_item.func == FUNC_PEEK;

    assign w_ctl.push = w_accept && w_is_push && !w_full;
    assign w_ctl.pop  = w_accept && w_is_pop && !w_empty;
    assign w_ctl.mode = r_mode;

    assign w_new_data = {TIME_BITS'(i_in_item.release_in),
                         TIME_BITS'(i_in_item.process_in),
                         TIME_BITS'(i_in_item.delivery_in)};

    assign w_found[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam int LI = (i == 0) ? 0 : i - 1;
        localparam int RI = (i == DEPTH - 1) ? i : i + 1;
        logic w_left_valid, w_right_valid;
        assign w_left_valid  = (i == 0) ? 1'b0 : w_valid[LI];
        assign w_right_valid = (i == DEPTH - 1) ? 1'b0 : w_valid[RI];
        stpq_cell #(
            .TIME_BITS(TIME_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_new_data   (w_new_data),
            .i_left_data  (w_data[LI]),
            .i_left_valid (w_left_valid),
            .i_right_data (w_data[RI]),
            .i_right_valid(w_right_valid),
            .i_found      (w_found[i]),
            .o_found      (w_found[i+1]),
            .o_data       (w_data[i]),
            .o_valid      (w_valid[i])
        );
    end

    assign w_head_rel  = w_data[0][3*TIME_BITS-1:2*TIME_BITS];
    assign w_head_proc = w_data[0][2*TIME_BITS-1:TIME_BITS];
    assign w_head_del  = w_data[0][TIME_BITS-1:0];

    always_comb begin
        n_count = r_count;
        if (w_ctl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        n_out_item              = '0;
        n_out_item.entry_count  = COUNT_W'(n_count);
        n_out_item.is_empty     = (n_count == '0);
        if (w_is_push && w_full) begin
            n_out_item.status = STAT_FULL;
        end else if (w_is_pop || w_is_peek) begin
            if (w_empty) begin
                n_out_item.status = STAT_EMPTY;
            end else begin
                n_out_item.release_out  = FIELD_W'(w_head_rel);
                n_out_item.process_out  = FIELD_W'(w_head_proc);
                n_out_item.delivery_out = FIELD_W'(w_head_del);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RELEASE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// Sorted task priority queue testbench
// Drives push, pop, peek and reserved operations in both order modes, with
// random gaps on the input and random stalls on the output. A software copy of the queue
// predicts every result, and each returned item is checked field by field.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stpq_pkg::*;

    localparam int WATCHDOG  = 3000;
    localparam int LONG_HOLD = 300;
    localparam int PHASES    = 12;

    typedef struct packed {
        logic [FIELD_W-1:0] rel;
        logic [FIELD_W-1:0] proc;
        logic [FIELD_W-1:0] del;
    } t_job;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} t_phase_kind;

    class task_queue_mirror;
        t_job      held_jobs[$];
        t_out_item expected_results[$];
        logic      order_mode = MODE_RELEASE;
        int        errors = 0;

        function void set_mode(logic m);
            order_mode = m;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_item(t_in_item it);
            t_out_item res;
            t_job      job;
            int        pos;
            res = '0;
            job = '{rel: it.release_in, proc: it.process_in, del: it.delivery_in};
            case (it.func)
                FUNC_PUSH: begin
                    if (held_jobs.size() >= DEPTH_DEF) begin
                        res.status = STAT_FULL;
                    end else begin
                        // The new task goes in front of the first held task
                        // that ranks strictly behind it.
                        pos = held_jobs.size();
                        for (int i = held_jobs.size() - 1; i >= 0; i--) begin
                            if (order_mode == MODE_RELEASE ? held_jobs[i].rel > job.rel
                                                           : held_jobs[i].del < job.del)
                                pos = i;
                        end
                        held_jobs.insert(pos, job);
                    end
                end
                FUNC_POP, FUNC_PEEK: begin
                    if (held_jobs.size() == 0) begin
                        res.status = STAT_EMPTY;
                    end else begin
                        res.release_out  = held_jobs[0].rel;
                        res.process_out  = held_jobs[0].proc;
                        res.delivery_out = held_jobs[0].del;
                        if (it.func == FUNC_POP)
                            void'(held_jobs.pop_front());
                    end
                end
                default: ;
            endcase
            res.entry_count = COUNT_W'(held_jobs.size());
            res.is_empty    = (held_jobs.size() == 0);
            expected_results = {expected_results, res};
        endfunction

        function void compare_field(string name, int unsigned e, int unsigned a);
            if (e != a) begin
                $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_item;
            if (expected_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            exp_item = expected_results.pop_front();
            compare_field("status", exp_item.status, got.status);
            compare_field("release_out", exp_item.release_out, got.release_out);
            compare_field("process_out", exp_item.process_out, got.process_out);
            compare_field("delivery_out", exp_item.delivery_out, got.delivery_out);
            compare_field("entry_count", exp_item.entry_count, got.entry_count);
            compare_field("is_empty", exp_item.is_empty, got.is_empty);
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;
    logic      i_cfg_we = 1'b0;
    logic      i_cfg_data = 1'b0;

    task_queue_mirror mirror = new();
    bit  hold_req = 1'b0;
    bit  no_gaps = 1'b0;
    int  idle_cycles = 0;

    sorted_task_priority_queue u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #10ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            mirror.check_result(o_out_item);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int r;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                hold_req = 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 9);
                if (r < 5) begin
                    i_out_stall <= 1'b0;
                    repeat ($urandom_range(0, 7)) @(posedge i_clk);
                end else if (r < 8) begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(0, 2)) @(posedge i_clk);
                end else if (r == 8) begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(10, 40)) @(posedge i_clk);
                end else begin
                    i_out_stall <= 1'b0;
                    repeat ($urandom_range(30, 80)) @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_item(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        mirror.note_item(it);
    endtask

    task automatic gap_in();
        int r;
        int n;
        r = $urandom_range(0, 9);
        n = 0;
        if (!no_gaps) begin
            if (r >= 5 && r < 9)
                n = $urandom_range(1, 3);
            else if (r == 9)
                n = $urandom_range(10, 40);
        end
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic do_op(input logic [1:0] f, input logic [FIELD_W-1:0] rel,
                         input logic [FIELD_W-1:0] proc, input logic [FIELD_W-1:0] del);
        t_in_item it;
        it = '{func: f, release_in: rel, process_in: proc, delivery_in: del};
        send_item(it);
        gap_in();
    endtask

    task automatic drain_queue();
        i_in_valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        drain_queue();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mirror.set_mode(m);
    endtask

    function automatic logic [FIELD_W-1:0] rand_time();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return FIELD_W'($urandom_range(0, 7));
            default: return FIELD_W'($urandom());
        endcase
    endfunction

    function automatic logic [1:0] pick_func(t_phase_kind kind);
        int r;
        int push_pct;
        int pop_pct;
        r = $urandom_range(0, 99);
        case (kind)
            PH_FILL:  begin push_pct = 85; pop_pct = 8;  end
            PH_DRAIN: begin push_pct = 25; pop_pct = 60; end
            default:  begin push_pct = 50; pop_pct = 30; end
        endcase
        if (r < push_pct)
            return FUNC_PUSH;
        if (r < push_pct + pop_pct)
            return FUNC_POP;
        if (r < 97)
            return FUNC_PEEK;
        return FUNC_RSVD;
    endfunction

    initial begin
        t_phase_kind kind;
        logic        m;
        int          count;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        do_op(FUNC_POP, '0, '0, '0);
        do_op(FUNC_PEEK, '1, '1, '1);
        do_op(FUNC_RSVD, '1, '1, '1);
        do_op(FUNC_PUSH, '1, '1, '1);
        do_op(FUNC_PUSH, '0, '0, '0);
        do_op(FUNC_PUSH, 16'h8000, 16'd1, 16'd2);
        do_op(FUNC_PUSH, 16'h8000, 16'd3, 16'd4);
        do_op(FUNC_PEEK, '0, '0, '0);
        do_op(FUNC_RSVD, '0, '0, '0);
        repeat (4) do_op(FUNC_POP, '0, '0, '0);
        do_op(FUNC_POP, '0, '0, '0);
        do_op(FUNC_PUSH, 16'd10, 16'd1, 16'd100);
        do_op(FUNC_PUSH, 16'd5, 16'd2, 16'd50);
        write_mode(MODE_DELIVERY);
        do_op(FUNC_PUSH, 16'd7, 16'd3, 16'd60);
        do_op(FUNC_PUSH, 16'd1, 16'd4, 16'd60);
        repeat (4) do_op(FUNC_POP, '1, '1, '1);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph % 3 == 0)
                m = MODE_RELEASE;
            else if (ph % 3 == 1)
                m = MODE_DELIVERY;
            else
                m = 1'($urandom_range(0, 1));
            write_mode(m);
            kind    = t_phase_kind'(ph % 3);
            no_gaps = (ph % 4 == 3);
            if (ph == 1)
                hold_req = 1'b1;
            count = $urandom_range(55, 80);
            repeat (count)
                do_op(pick_func(kind), rand_time(), rand_time(), rand_time());
        end

        drain_queue();
        repeat (5) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

/* files.f */
src/stpq_pkg.sv
src/stpq_cell.sv
src/sorted_task_priority_queue.sv
sim/tb.sv
